### sv/rrts_pkg.sv
// Package: shared types, constants and helpers for the round-robin tick scheduler.
package rrts_pkg;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned OCCW   = $clog2(QDEPTH + 1);

  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [1:0] {
    CMD_ARRIVE,
    CMD_REJECT,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  job_id;
    logic [15:0] burst;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] rem;
  } job_t;

  typedef struct packed {
    logic [15:0] slot;
    logic        busy_res;
    logic [7:0]  run_id;
    logic        finished;
    logic        dropped;
  } result_t;

  function automatic logic [QAW-1:0] next_idx(input logic [QAW-1:0] p);
    logic [QAW-1:0] r;
    if (p == QAW'(QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QAW'(1);
    end
    return r;
  endfunction

endpackage

### sv/rrts_if.sv
// Interfaces: input item channel and result channel with valid/ready handshake.
interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  job_id;
  logic [15:0] burst;

  modport source (output valid, output mode, output job_id, output burst, input ready);
  modport sink   (input valid, input mode, input job_id, input burst, output ready);
endinterface

interface rrts_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] slot;
  logic        busy_res;
  logic [7:0]  run_id;
  logic        finished;
  logic        dropped;

  modport source (output valid, output slot, output busy_res, output run_id,
                  output finished, output dropped, input ready);
  modport sink   (input valid, input slot, input busy_res, input run_id,
                  input finished, input dropped, output ready);
endinterface

### sv/round_robin_tick_scheduler_core.sv
// Top level: round-robin tick scheduler with a one-slot quantum.
// Arrival items queue a job (job_id, burst) in a 16-entry ready FIFO; tick items
// report one time slot each: a job held back from the previous slot rejoins the
// tail, then the head runs one slot and is reported finished or held back again.
// Zero-burst arrivals and arrivals that find the FIFO (plus the held job) full are
// dropped and flagged on the next tick. An accepted item is classified and parked
// in a two-entry command queue; the back end carries it out at the next edge at the
// earliest, so a tick's slot report sits in the result register from then on until
// it is taken downstream. Each item writes at most one FIFO entry. The back end never
// stalls an arrival, but the input does while the command queue is full; a tick
// waits only while the previous report has not been taken downstream, so with the
// output drained the block takes one item per cycle.
module round_robin_tick_scheduler_core
  import rrts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rrts_in_if.sink     in_i,
  rrts_out_if.source  out_o
);

  logic    cmd_valid;
  logic    cmd_ready;
  cmd_t    cmd;
  result_t res;

  rrts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_mode_i   (in_i.mode),
    .in_job_id_i (in_i.job_id),
    .in_burst_i  (in_i.burst),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  rrts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.slot     = res.slot;
  assign out_o.busy_res = res.busy_res;
  assign out_o.run_id   = res.run_id;
  assign out_o.finished = res.finished;
  assign out_o.dropped  = res.dropped;

endmodule

### sv/rrts_front.sv
// Front end: accepts input items, classifies them and queues commands for the back end.
module rrts_front
  import rrts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_mode_i,
  input  logic [7:0]  in_job_id_i,
  input  logic [15:0] in_burst_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  cmd_t       buf_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.job_id = in_job_id_i;
    cmd_in.burst  = in_burst_i;
    if (in_mode_i == MODE_TICK) begin
      cmd_in.kind = CMD_TICK;
    end else if (in_burst_i == 16'd0) begin
      cmd_in.kind = CMD_REJECT;
    end else begin
      cmd_in.kind = CMD_ARRIVE;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop  ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### sv/rrts_back.sv
// Back end: ready FIFO, held job, slot counter and registered result output.
module rrts_back
  import rrts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  output logic    cmd_ready_o,
  input  cmd_t    cmd_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  job_t            store_q [QDEPTH];
  logic [QAW-1:0]  head_q, head_d;
  logic [QAW-1:0]  tail_q, tail_d;
  logic [OCCW-1:0] occ_q, occ_d;
  logic            held_q, held_d;
  job_t            held_job_q, held_job_d;
  logic [15:0]     slot_q, slot_d;
  logic            drop_q, drop_d;
  logic            res_valid_q, res_valid_d;
  result_t         res_q, res_d;

  logic            fire, is_tick;
  logic            full;
  logic            wr_en;
  job_t            wr_job;
  logic            busy;
  job_t            run_job;
  logic [15:0]     rem_dec;

  assign is_tick     = (cmd_i.kind == CMD_TICK);
  assign cmd_ready_o = !is_tick || !res_valid_q || res_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign full        = ({1'b0, occ_q} + {{OCCW{1'b0}}, held_q}) >= (OCCW+1)'(QDEPTH);
  assign busy        = (occ_q != '0) || held_q;
  assign run_job     = (occ_q == '0) ? held_job_q : store_q[head_q];
  assign rem_dec     = run_job.rem - 16'd1;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    held_d      = held_q;
    held_job_d  = held_job_q;
    slot_d      = slot_q;
    drop_d      = drop_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_job      = held_job_q;
    if (fire) begin
      unique case (cmd_i.kind)
        CMD_ARRIVE: begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            wr_en  = 1'b1;
            wr_job = '{id: cmd_i.job_id, rem: cmd_i.burst};
            tail_d = next_idx(tail_q);
            occ_d  = occ_q + OCCW'(1);
          end
        end
        CMD_REJECT: begin
          drop_d = 1'b1;
        end
        CMD_TICK: begin
          if (occ_q != '0) begin
            head_d = next_idx(head_q);
            if (held_q) begin
              wr_en  = 1'b1;
              tail_d = next_idx(tail_q);
            end else begin
              occ_d = occ_q - OCCW'(1);
            end
          end
          held_d = busy && (rem_dec != 16'd0);
          if (busy) begin
            held_job_d = '{id: run_job.id, rem: rem_dec};
          end
          res_d.slot     = slot_q;
          res_d.busy_res = busy;
          res_d.run_id   = busy ? run_job.id : 8'd0;
          res_d.finished = busy && (rem_dec == 16'd0);
          res_d.dropped  = drop_q;
          res_valid_d    = 1'b1;
          drop_d         = 1'b0;
          slot_d         = slot_q + 16'd1;
        end
        default: begin
          drop_d = drop_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[tail_q] <= wr_job;
    end
  end

  always_ff @(posedge clk_i) begin
    held_job_q <= held_job_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      held_q      <= 1'b0;
      slot_q      <= 16'd0;
      drop_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      held_q      <= held_d;
      slot_q      <= slot_d;
      drop_q      <= drop_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### tb/sv/rrts_checker.sv
// Checker: watches both channels, predicts each slot report and compares it.
module rrts_checker
  import rrts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rrts_in_if          in_mon,
  rrts_out_if         out_mon,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);

  job_t           ready_q [QDEPTH];
  logic [QAW-1:0] rd_ptr    = '0;
  logic [QAW-1:0] wr_ptr    = '0;
  int unsigned    fill      = 0;
  bit             held_v    = 1'b0;
  job_t           held      = '0;
  logic [15:0]    slot_nr   = '0;
  bit             drop_seen = 1'b0;
  result_t        slot_reports [$];

  function automatic logic [QAW-1:0] bump_ptr(input logic [QAW-1:0] p);
    return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic void push_ready(input job_t j);
    ready_q[wr_ptr] = j;
    wr_ptr = bump_ptr(wr_ptr);
    fill++;
  endfunction

  // Returns 1 when the item produces a slot report.
  function automatic bit schedule_item(input logic mode, input logic [7:0] id,
                                       input logic [15:0] burst, output result_t rep);
    job_t run;
    rep = '0;
    if (mode == MODE_ARRIVE) begin
      // held job keeps a place reserved
      if (burst == 16'd0 || fill + held_v >= QDEPTH) begin
        drop_seen = 1'b1;
      end else begin
        push_ready({id, burst});
      end
      return 1'b0;
    end
    if (held_v && fill < QDEPTH) begin
      push_ready(held);
    end
    held_v = 1'b0;
    rep.slot = slot_nr;
    rep.dropped = drop_seen;
    if (fill != 0) begin
      run = ready_q[rd_ptr];
      rd_ptr = bump_ptr(rd_ptr);
      fill--;
      rep.busy_res = 1'b1;
      rep.run_id = run.id;
      run.rem = run.rem - 16'd1;
      if (run.rem == 16'd0) begin
        rep.finished = 1'b1;
      end else begin
        held = run;
        held_v = 1'b1;
      end
    end
    drop_seen = 1'b0;
    slot_nr = slot_nr + 16'd1;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    result_t rep;
    if (!rst_ni) begin
      rd_ptr = '0;
      wr_ptr = '0;
      fill = 0;
      held_v = 1'b0;
      held = '0;
      slot_nr = '0;
      drop_seen = 1'b0;
      slot_reports.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.slot = out_mon.slot;
        got.busy_res = out_mon.busy_res;
        got.run_id = out_mon.run_id;
        got.finished = out_mon.finished;
        got.dropped = out_mon.dropped;
        if (slot_reports.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 10) begin
            $display("%0t: unexpected slot report slot=%0d busy=%0b id=%0d fin=%0b drop=%0b",
                     $time, got.slot, got.busy_res, got.run_id, got.finished, got.dropped);
          end
        end else begin
          want = slot_reports.pop_front();
          if (got.slot !== want.slot || got.busy_res !== want.busy_res ||
              got.run_id !== want.run_id || got.finished !== want.finished ||
              got.dropped !== want.dropped) begin
            err_cnt_o++;
            if (err_cnt_o <= 10) begin
              $display("%0t: slot report mismatch exp slot=%0d busy=%0b id=%0d fin=%0b drop=%0b",
                       $time, want.slot, want.busy_res, want.run_id, want.finished,
                       want.dropped);
              $display("%0t:                      got slot=%0d busy=%0b id=%0d fin=%0b drop=%0b",
                       $time, got.slot, got.busy_res, got.run_id, got.finished, got.dropped);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (schedule_item(in_mon.mode, in_mon.job_id, in_mon.burst, rep)) begin
          slot_reports.push_back(rep);
        end
      end
    end
    pending_o = slot_reports.size();
  end

endmodule

### tb/sv/testbench.sv
// Testbench top: clock, reset, stimulus for arrivals and ticks, and the verdict.
module testbench;
  import rrts_pkg::*;

  typedef enum int unsigned {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_BLOCKS
  } rx_pattern_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned err_cnt;
  int unsigned pending;

  rrts_in_if  in_if ();
  rrts_out_if out_if ();

  round_robin_tick_scheduler_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rrts_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stall pattern
  rx_pattern_e rx_pattern = RX_OPEN;
  int unsigned rx_span    = 0;
  int unsigned rx_hold    = 0;

  always @(posedge clk_i) begin
    if (rx_span == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 200);
    end else begin
      rx_span--;
    end
    case (rx_pattern)
      RX_OPEN: begin
        out_if.ready <= 1'b1;
      end
      RX_RANDOM: begin
        out_if.ready <= 1'($urandom_range(0, 1));
      end
      RX_PERIODIC: begin
        out_if.ready <= (rx_span % 4) != 0;
      end
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 8);
          out_if.ready <= 1'b1;
        end else begin
          rx_hold--;
          out_if.ready <= 1'b0;
        end
      end
    endcase
  end

  // sender: bursts of transfers separated by gaps
  int unsigned burst_left = 0;
  bit          no_gaps    = 1'b0;

  task automatic send_item(input logic mode, input logic [7:0] id, input logic [15:0] burst);
    int unsigned gap;
    in_if.valid  <= 1'b1;
    in_if.mode   <= mode;
    in_if.job_id <= id;
    in_if.burst  <= burst;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int unsigned tick_pct;
    int unsigned pick;
    logic [15:0] burst;
    in_if.valid  <= 1'b0;
    in_if.mode   <= MODE_ARRIVE;
    in_if.job_id <= 8'd0;
    in_if.burst  <= 16'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_item(MODE_TICK, 8'd0, 16'd0);
    send_item(MODE_ARRIVE, 8'd0, 16'd1);
    send_item(MODE_TICK, 8'd0, 16'd0);
    send_item(MODE_ARRIVE, 8'hFF, 16'hFFFF);
    send_item(MODE_ARRIVE, 8'h5A, 16'd0);
    send_item(MODE_TICK, 8'hFF, 16'hFFFF);
    // fill up to the reserved place of the held job; the last one is dropped
    for (int i = 1; i <= 16; i++) begin
      send_item(MODE_ARRIVE, 8'(i), 16'd2);
    end
    send_item(MODE_TICK, 8'h00, 16'h0000);
    send_item(MODE_TICK, 8'hA5, 16'h5A5A);

    // back-to-back tick run: the short jobs drain, the long one keeps rotating
    no_gaps = 1'b1;
    repeat (40) send_item(MODE_TICK, 8'($urandom), 16'($urandom));
    no_gaps = 1'b0;

    // random traffic, phases lean toward filling or draining
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 2))
        0: tick_pct = 20;
        1: tick_pct = 50;
        default: tick_pct = 80;
      endcase
      repeat (100) begin
        if ($urandom_range(1, 100) <= tick_pct) begin
          send_item(MODE_TICK, 8'($urandom), 16'($urandom));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            burst = 16'd0;
          end else if (pick < 90) begin
            burst = 16'($urandom_range(1, 4));
          end else if (pick < 98) begin
            burst = 16'($urandom_range(5, 40));
          end else begin
            burst = 16'($urandom);
          end
          send_item(MODE_ARRIVE, 8'($urandom), burst);
        end
      end
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
